@@ design/sva_pkg.sv @@
// Shared types, codes and sizes for the synth voice allocator.
package sva_pkg;

    localparam int MAX_VOICES = 16;
    localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W      = $clog2(MAX_VOICES + 1);

    localparam logic [6:0] AV_RESET      = 7'd16;
    localparam logic [7:0] ECHO_CH_LIMIT = 8'd15;

    // Command codes carried in the input item's tuser.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Voice status codes.
    localparam logic [1:0] ST_OFF   = 2'd0;
    localparam logic [1:0] ST_HELD  = 2'd1;
    localparam logic [1:0] ST_DECAY = 2'd2;

    // Choice kinds reported with a result.
    localparam logic [2:0] KIND_SAME   = 3'd0;
    localparam logic [2:0] KIND_FREE   = 3'd1;
    localparam logic [2:0] KIND_DECAY  = 3'd2;
    localparam logic [2:0] KIND_ECHO   = 3'd3;
    localparam logic [2:0] KIND_FORCED = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_scan;
        logic start_ge;
        logic scan_last;
    } dp_status_t;

endpackage

@@ design/sva_ctrl.sv @@
// Sequencing state machine of the voice allocator.
module sva_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  m_ready,
    input  sva_pkg::dp_status_t   status,
    output sva_pkg::ctrl_cmd_t    cmd,
    output logic                  s_ready,
    output logic                  m_valid
);

    sva_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sva_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sva_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = status.in_scan ? sva_pkg::S_MOD : sva_pkg::S_DONE;
                end
            end
            sva_pkg::S_MOD: begin
                if (!status.start_ge) begin
                    state_next = sva_pkg::S_SCAN;
                end
            end
            sva_pkg::S_SCAN: begin
                if (status.scan_last) begin
                    state_next = sva_pkg::S_DONE;
                end
            end
            sva_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = sva_pkg::S_IDLE;
                end
            end
            default: state_next = sva_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        case (state_reg)
            sva_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            sva_pkg::S_MOD:  cmd.mod_step  = status.start_ge;
            sva_pkg::S_SCAN: cmd.scan_step = 1'b1;
            sva_pkg::S_DONE: cmd.finish    = out_free;
            default: cmd = '0;
        endcase
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ design/sva_datapath.sv @@
// Voice table, scan registers and result register of the voice allocator.
module sva_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sva_pkg::ctrl_cmd_t          cmd,
    input  logic [6:0]                  active_voices,
    input  logic [1:0]                  in_cmd,
    input  logic [7:0]                  in_channel,
    input  logic [6:0]                  in_note,
    input  logic [5:0]                  in_slot,
    input  logic [1:0]                  in_new_status,
    input  logic                        in_new_echo,
    output sva_pkg::dp_status_t         status,
    output logic                        found,
    output logic [5:0]                  chosen_slot,
    output logic [2:0]                  choice_kind
);

    localparam int IW = sva_pkg::IDX_W;
    localparam int CW = sva_pkg::CNT_W;
    localparam int NV = sva_pkg::MAX_VOICES;

    logic [1:0]    vstat_reg  [NV];
    logic [6:0]    vpitch_reg [NV];
    logic [7:0]    vchan_reg  [NV];
    logic          vecho_reg  [NV];

    logic [1:0]    cmd_reg;
    logic [7:0]    ch_reg;
    logic [6:0]    note_reg;
    logic [CW-1:0] start_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] last_used_reg;
    logic          lin_hit_reg;
    logic [IW-1:0] lin_idx_reg;
    // Round-robin trackers, one per search kind: free, decaying, echo.
    logic [2:0]    any_hit_reg, ge_hit_reg;
    logic [IW-1:0] any_idx_reg [3];
    logic [IW-1:0] ge_idx_reg  [3];

    logic          found_reg;
    logic [5:0]    slot_out_reg;
    logic [2:0]    kind_reg;

    logic [CW-1:0] n_eff;
    logic          wr_en;
    logic          lin_test;
    logic [2:0]    rr_test;
    logic          at_or_past_start;
    logic          res_found;
    logic [IW-1:0] res_idx;
    logic [2:0]    res_kind;

    // The usable voice count is the register clamped to 1..MAX_VOICES.
    always_comb begin
        if (active_voices == 7'd0) begin
            n_eff = CW'(1);
        end else if (active_voices > 7'(NV)) begin
            n_eff = CW'(NV);
        end else begin
            n_eff = CW'(active_voices);
        end
    end

    assign wr_en = cmd.load && (in_cmd == sva_pkg::CMD_WRITE) && (7'(in_slot) < 7'(n_eff));

    assign status.in_scan   = (in_cmd == sva_pkg::CMD_ALLOC) || (in_cmd == sva_pkg::CMD_FIND);
    assign status.start_ge  = start_reg >= n_eff;
    assign status.scan_last = CW'(idx_reg) == (n_eff - CW'(1));

    always_comb begin
        if (cmd_reg == sva_pkg::CMD_ALLOC) begin
            lin_test = vstat_reg[idx_reg] != sva_pkg::ST_OFF;
        end else begin
            lin_test = vstat_reg[idx_reg] == sva_pkg::ST_HELD;
        end
        lin_test = lin_test && (vpitch_reg[idx_reg] == note_reg)
                   && (vchan_reg[idx_reg] == ch_reg);
        rr_test[0] = vstat_reg[idx_reg] == sva_pkg::ST_OFF;
        rr_test[1] = vstat_reg[idx_reg] == sva_pkg::ST_DECAY;
        rr_test[2] = vecho_reg[idx_reg];
        at_or_past_start = CW'(idx_reg) >= start_reg;
    end

    // Pick the result from the trackers once the scan has finished.
    always_comb begin
        res_found = 1'b0;
        res_idx   = '0;
        res_kind  = sva_pkg::KIND_SAME;
        if (cmd_reg == sva_pkg::CMD_ALLOC) begin
            if (lin_hit_reg) begin
                res_found = 1'b1;
                res_idx   = lin_idx_reg;
            end else if (any_hit_reg[0]) begin
                res_found = 1'b1;
                res_idx   = ge_hit_reg[0] ? ge_idx_reg[0] : any_idx_reg[0];
                res_kind  = sva_pkg::KIND_FREE;
            end else if (any_hit_reg[1]) begin
                res_found = 1'b1;
                res_idx   = ge_hit_reg[1] ? ge_idx_reg[1] : any_idx_reg[1];
                res_kind  = sva_pkg::KIND_DECAY;
            end else if (any_hit_reg[2]) begin
                res_found = 1'b1;
                res_idx   = ge_hit_reg[2] ? ge_idx_reg[2] : any_idx_reg[2];
                res_kind  = sva_pkg::KIND_ECHO;
            end else if (ch_reg <= sva_pkg::ECHO_CH_LIMIT) begin
                res_found = 1'b1;
                res_idx   = start_reg[IW-1:0];
                res_kind  = sva_pkg::KIND_FORCED;
            end
        end else if (cmd_reg == sva_pkg::CMD_FIND) begin
            if (lin_hit_reg) begin
                res_found = 1'b1;
                res_idx   = lin_idx_reg;
            end
        end
    end

    // Voice table and allocation pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) begin
                vstat_reg[i]  <= sva_pkg::ST_OFF;
                vpitch_reg[i] <= '0;
                vchan_reg[i]  <= '0;
                vecho_reg[i]  <= 1'b0;
            end
            last_used_reg <= '0;
        end else begin
            if (wr_en) begin
                vstat_reg[in_slot[IW-1:0]]  <= in_new_status;
                vpitch_reg[in_slot[IW-1:0]] <= in_note;
                vchan_reg[in_slot[IW-1:0]]  <= in_channel;
                vecho_reg[in_slot[IW-1:0]]  <= in_new_echo;
            end
            if (cmd.finish && (cmd_reg == sva_pkg::CMD_ALLOC) && res_found) begin
                last_used_reg <= res_idx;
            end
        end
    end

    // Scan state; reduces the start point modulo the count, then walks the table.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg     <= in_cmd;
            ch_reg      <= in_channel;
            note_reg    <= in_note;
            start_reg   <= CW'(last_used_reg) + CW'(1);
            idx_reg     <= '0;
            lin_hit_reg <= 1'b0;
            lin_idx_reg <= '0;
            any_hit_reg <= '0;
            ge_hit_reg  <= '0;
            for (int k = 0; k < 3; k++) begin
                any_idx_reg[k] <= '0;
                ge_idx_reg[k]  <= '0;
            end
        end else if (cmd.mod_step) begin
            start_reg <= start_reg - n_eff;
        end else if (cmd.scan_step) begin
            if (lin_test && !lin_hit_reg) begin
                lin_hit_reg <= 1'b1;
                lin_idx_reg <= idx_reg;
            end
            for (int k = 0; k < 3; k++) begin
                if (rr_test[k] && !any_hit_reg[k]) begin
                    any_hit_reg[k] <= 1'b1;
                    any_idx_reg[k] <= idx_reg;
                end
                if (rr_test[k] && at_or_past_start && !ge_hit_reg[k]) begin
                    ge_hit_reg[k] <= 1'b1;
                    ge_idx_reg[k] <= idx_reg;
                end
            end
            idx_reg <= idx_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            found_reg    <= res_found;
            slot_out_reg <= 6'(res_idx);
            kind_reg     <= res_kind;
        end
    end

    assign found       = found_reg;
    assign chosen_slot = slot_out_reg;
    assign choice_kind = kind_reg;

endmodule

@@ design/synth_voice_allocator.sv @@
// Top level of the polyphonic voice allocator with round-robin stealing.
//
// Input items arrive on the s_axis channel: tuser carries the command (allocate,
// find a held voice, write a table entry) and tdata carries the channel, note,
// slot, new status and echo flag. Every input item yields exactly one result item
// on the m_axis channel with found, chosen_slot and choice_kind.
// The register active_voices sits on the APB port at byte address 0.
// The user must change configuration only while the block is idle; the block itself does not enforce this.
//
// A write or an unused command goes from acceptance straight to the done state, without a scan.
// An allocate or find first performs M subtractions, where M, at most MAX_VOICES,
// is the number that bring last_used + 1 below N, the effective voice count;
// then the datapath examines the N table entries, one table entry per cycle.
// One item is processed at a time; the next item is accepted once the result
// has moved into the output register, even while that result waits.
// If the receiver stalls, the result holds in the output register and the
// controller waits before finishing the following item.
// Reset clears the voice table to all off, sets last_used to zero and sets
// active_voices to 16.
module synth_voice_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // channel[7:0], note[14:8], slot[20:15],
                                       // new_status[22:21], new_echo[23]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // found[0], chosen_slot[6:1],
                                       // choice_kind[9:7], zero[15:10]
);

    logic [6:0]          active_voices_reg;
    sva_pkg::ctrl_cmd_t  cmd;
    sva_pkg::dp_status_t status;
    logic                found;
    logic [5:0]          chosen_slot;
    logic [2:0]          choice_kind;
    logic                cfg_write;

    // The register occupies word 0; writes to the other word are dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_voices_reg <= sva_pkg::AV_RESET;
        end else if (cfg_write) begin
            active_voices_reg <= pwdata[6:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(active_voices_reg);

    sva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid)
    );

    sva_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .active_voices (active_voices_reg),
        .in_cmd        (s_axis_tuser),
        .in_channel    (s_axis_tdata[7:0]),
        .in_note       (s_axis_tdata[14:8]),
        .in_slot       (s_axis_tdata[20:15]),
        .in_new_status (s_axis_tdata[22:21]),
        .in_new_echo   (s_axis_tdata[23]),
        .status        (status),
        .found         (found),
        .chosen_slot   (chosen_slot),
        .choice_kind   (choice_kind)
    );

    assign m_axis_tdata = {6'd0, choice_kind, chosen_slot, found};

`ifndef SYNTHESIS
    // A result that names no voice carries all-zero slot and kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[9:1] == 9'd0))
        else $error("empty result with nonzero slot or kind");

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // A returned voice lies inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[0]) |->
        (m_axis_tdata[6:1] < 6'(sva_pkg::MAX_VOICES)))
        else $error("chosen slot outside the voice table");

    // Only defined choice kinds are reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[9:7] <= sva_pkg::KIND_FORCED))
        else $error("undefined choice kind");
`endif

endmodule
